/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
// No dependencies; each macro takes a label, clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/srer_pkg.sv */
// Package for the shift-reduce expression recognizer.
// Holds the grammar symbol codes and field widths; no dependencies.
package srer_pkg;

  // Field widths of a result word
  localparam int DEPTH_W = 7;
  localparam int SYM_W   = 8;
  localparam int RED_W   = 7;

  // Grammar symbols
  localparam logic [SYM_W-1:0] SYM_I   = 8'h69; // 'i'
  localparam logic [SYM_W-1:0] SYM_E   = 8'h45; // 'E'
  localparam logic [SYM_W-1:0] SYM_MUL = 8'h2A; // '*'
  localparam logic [SYM_W-1:0] SYM_ADD = 8'h2B; // '+'
  localparam logic [SYM_W-1:0] SYM_LP  = 8'h28; // '('
  localparam logic [SYM_W-1:0] SYM_RP  = 8'h29; // ')'
  localparam logic [SYM_W-1:0] SYM_END = 8'h24; // '$'

endpackage

/* rtl/srer_stack.sv */
// Symbol stack storage: one write port, two read ports, registered reads.
// Depends on srer_pkg for the symbol width.
module srer_stack import srer_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [SYM_W-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [SYM_W-1:0] rdata_a,
  output logic [SYM_W-1:0] rdata_b
);

  logic [SYM_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/shift_reduce_expression_recognizer.sv */
// Top level of the shift-reduce recognizer for E -> E+E | E*E | (E) | i.
// Depends on srer_pkg and srer_stack.
//
// One input word is one character; each produces one result word. A word
// is accepted with a push (none for '$' or a full stack), then the top three
// symbols are checked in ST_EVAL; each 'i' promoted to E repeats the check,
// and each three-symbol reduction passes through ST_FILL, which waits on the
// stack memory read that refills the cached second and third symbols. The full
// stack lives in a memory with registered reads; the top three symbols are
// mirrored in registers so a push never reads the memory. A result that is
// not yet taken holds the block in its final check until the output
// register frees up. The stack needs no clearing after reset.
module shift_reduce_expression_recognizer import srer_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SYM_W-1:0]   symbol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [DEPTH_W-1:0] stack_depth,
  output logic [SYM_W-1:0]   top_symbol,
  output logic [RED_W-1:0]   reductions,
  output logic               end_seen,
  output logic               accepted,
  output logic               overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;

  logic [1:0]       state;
  logic [CW-1:0]    count;
  logic             ovf;
  logic             is_end;
  logic [RED_W-1:0] red;
  // s0 is the top of stack; sK is valid only while count > K
  logic [SYM_W-1:0] s0, s1, s2;

  logic [CW-1:0]    cm1, cm3, cm4, cm5;
  logic             red_i, red_3, out_free, accept_in, emit;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [SYM_W-1:0] wdata;
  logic [SYM_W-1:0] rdata_a, rdata_b;

  assign cm1 = count - CW'(1);
  assign cm3 = count - CW'(3);
  assign cm4 = count - CW'(4);
  assign cm5 = count - CW'(5);

  assign in_ready  = (state == ST_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Reduction checks on the cached top of stack
  assign red_i = (count != '0) && (s0 == SYM_I);
  assign red_3 = (count >= CW'(3)) &&
                 (((s2 == SYM_E) && ((s1 == SYM_MUL) || (s1 == SYM_ADD)) && (s0 == SYM_E)) ||
                  ((s2 == SYM_LP) && (s1 == SYM_E) && (s0 == SYM_RP)));

  // Result word loads when the stack is stable and the output is free
  assign emit = (state == ST_EVAL) && !red_i && !red_3 && out_free;

  // Stack write: push on accept unless '$' or full, rewrite to E on a reduction
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = symbol;
    if (accept_in) begin
      we = (symbol != SYM_END) && (count < DEPTH_C);
    end else if (state == ST_EVAL) begin
      if (red_i) begin
        we    = 1'b1;
        waddr = cm1[AW-1:0];
        wdata = SYM_E;
      end else if (red_3) begin
        we    = 1'b1;
        waddr = cm3[AW-1:0];
        wdata = SYM_E;
      end
    end
  end

  srer_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (cm4[AW-1:0]),
    .raddr_b (cm5[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Sequencer: shift, reduce until stable, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            is_end <= (symbol == SYM_END);
            red    <= '0;
            state  <= ST_EVAL;
            if (symbol != SYM_END) begin
              if (count < DEPTH_C) begin
                count <= count + CW'(1);
                s0    <= symbol;
                s1    <= s0;
                s2    <= s1;
              end else begin
                ovf <= 1'b1;
              end
            end
          end
        end
        ST_EVAL: begin
          if (red_i) begin
            s0  <= SYM_E;
            red <= red + RED_W'(1);
          end else if (red_3) begin
            s0    <= SYM_E;
            count <= count - CW'(2);
            red   <= red + RED_W'(1);
            state <= ST_FILL;
          end else if (out_free) begin
            stack_depth <= DEPTH_W'(count);
            top_symbol  <= (count != '0) ? s0 : '0;
            reductions  <= red;
            end_seen    <= is_end;
            accepted    <= is_end && (count == CW'(1)) && (s0 == SYM_E) && !ovf;
            overflow    <= ovf;
            if (is_end) begin
              count <= '0;
              ovf   <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          // refill the entries below the new top
          s1    <= rdata_a;
          s2    <= rdata_b;
          state <= ST_EVAL;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/srer_checker.sv */
// Port-level checker for the shift-reduce recognizer, bound to the top.
// Depends on srer_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srer_checker import srer_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [SYM_W-1:0]   symbol,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DEPTH_W-1:0] stack_depth,
  input logic [SYM_W-1:0]   top_symbol,
  input logic [RED_W-1:0]   reductions,
  input logic               end_seen,
  input logic               accepted,
  input logic               overflow
);

  // A stalled result word holds its depth, top symbol, reduction count and accepted flag
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(stack_depth) && $stable(top_symbol) && $stable(reductions) && $stable(accepted))

  // Acceptance only on the end marker and never after an overflow
  `ASSERT_IMPL(a_acc_end, clk, rst, out_valid && accepted, end_seen && !overflow)

  // Acceptance means a single E on the stack
  `ASSERT_IMPL(a_acc_one_e, clk, rst, out_valid && accepted, (stack_depth == 7'd1) && (top_symbol == SYM_E))

  // Empty stack reports a zero top symbol
  `ASSERT_IMPL(a_empty_top, clk, rst, out_valid && (stack_depth == 7'd0), top_symbol == 8'd0)

endmodule

bind shift_reduce_expression_recognizer srer_checker u_srer_checker (.*);
